// ===== rtl/core/slug_pkg.sv =====
// Shared types, constants and the modular fold for the shuffled Lehmer generator.
// Used by the controller, the datapath and the top level; depends on nothing.
package slug_pkg;

	localparam logic [14:0] LEHMER_MUL = 15'd16807;
	localparam logic [30:0] LEHMER_MOD = 31'h7FFF_FFFF;
	localparam logic [31:0] SEED_RESET = 32'd123456;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SEED_ABS,
		ST_SEED_LD,
		ST_W_MUL,
		ST_W_RED,
		ST_W_WR,
		ST_D_MUL,
		ST_D_RED,
		ST_D_FIX,
		ST_D_RD,
		ST_D_OUT
	} slug_state_t;

	typedef struct packed {
		logic mag_en;
		logic seed_en;
		logic step_mul;
		logic step_red;
		logic warm_wr;
		logic slot_fix;
		logic draw_done;
	} dp_cmd_t;

	typedef struct packed {
		logic filled;
		logic warm_last;
		logic out_full;
	} dp_status_t;

	// Reduce p mod 2^31-1 for p below 2^46: fold the high bits onto the low bits.
	function automatic logic [30:0] lmod_fold(input logic [45:0] p);
		logic [31:0] s;
		logic [31:0] d;
		s = {1'b0, p[30:0]} + {17'b0, p[45:31]};
		d = s - {1'b0, LEHMER_MOD};
		return (s >= {1'b0, LEHMER_MOD}) ? d[30:0] : s[30:0];
	endfunction

endpackage

// ===== rtl/core/slug_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module slug_ram #(
	parameter int WIDTH = 31,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/core/slug_ctrl.sv =====
// Sequencer for seeding, table warm-up and shuffled draws.
// Depends on slug_pkg for the state type and the command and status structs.
module slug_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 draw,
	output logic                 in_stall,
	input  slug_pkg::dp_status_t st,
	output slug_pkg::dp_cmd_t    cmd
);
	import slug_pkg::*;

	slug_state_t state_q;
	slug_state_t state_d;
	logic        accept;

	assign accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && draw) begin
					state_d = st.filled ? ST_D_MUL : ST_SEED_ABS;
				end
			end
			ST_SEED_ABS: state_d = ST_SEED_LD;
			ST_SEED_LD:  state_d = ST_W_MUL;
			ST_W_MUL:    state_d = ST_W_RED;
			ST_W_RED:    state_d = ST_W_WR;
			ST_W_WR:     state_d = st.warm_last ? ST_D_MUL : ST_W_MUL;
			ST_D_MUL:    state_d = ST_D_RED;
			ST_D_RED:    state_d = ST_D_FIX;
			ST_D_FIX:    state_d = ST_D_RD;
			ST_D_RD:     state_d = ST_D_OUT;
			ST_D_OUT: begin
				if (!st.out_full) begin
					state_d = ST_IDLE;
				end
			end
			default:     state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE:     in_stall = 1'b0;
			ST_SEED_ABS: cmd.mag_en = 1'b1;
			ST_SEED_LD:  cmd.seed_en = 1'b1;
			ST_W_MUL:    cmd.step_mul = 1'b1;
			ST_W_RED:    cmd.step_red = 1'b1;
			ST_W_WR:     cmd.warm_wr = 1'b1;
			ST_D_MUL:    cmd.step_mul = 1'b1;
			ST_D_RED:    cmd.step_red = 1'b1;
			ST_D_FIX:    cmd.slot_fix = 1'b1;
			ST_D_RD:     cmd = '0;
			ST_D_OUT:    cmd.draw_done = !st.out_full;
			default:     cmd = '0;
		endcase
	end

endmodule

// ===== rtl/core/slug_dp.sv =====
// Datapath: seed register, Lehmer step, slot selection, shuffle table and output word.
// Depends on slug_pkg and slug_ram.
module slug_dp #(
	parameter int TABLE_SIZE = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 seed_wr_en,
	input  logic [31:0]          seed_wr_data,
	input  slug_pkg::dp_cmd_t    cmd,
	output slug_pkg::dp_status_t st,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [30:0]          deviate
);
	import slug_pkg::*;

	localparam int AW = $clog2(TABLE_SIZE);
	localparam int CW = $clog2(TABLE_SIZE + 8);
	localparam logic [31:0] SLOT_DIV = 32'(1 + (int'(LEHMER_MOD) - 1) / TABLE_SIZE);
	localparam logic [CW-1:0] WARM_START = CW'(TABLE_SIZE + 7);
	localparam logic [AW:0] SLOT_TOP = (AW + 1)'(TABLE_SIZE - 1);

	logic [31:0]    seed_q;
	logic [31:0]    mag_q;
	logic [30:0]    gen_q;
	logic [30:0]    last_q;
	logic [CW-1:0]  warm_q;
	logic [45:0]    gen_prod_s1;
	logic [30+AW:0] slot_prod_s1;
	logic [AW-1:0]  q0_s2;
	logic [31:0]    qd_s2;
	logic [AW-1:0]  slot_q;
	logic           out_valid_q;
	logic [30:0]    deviate_q;

	logic [30:0]    seed_red;
	logic [AW-1:0]  q0;
	logic [32:0]    qd_hi;
	logic           q_low;
	logic           q_up;
	logic [AW:0]    q_fix;
	logic           warm_in;
	logic           ram_we;
	logic [AW-1:0]  ram_waddr;
	logic [30:0]    ram_rdata;

	assign seed_red = lmod_fold({14'b0, mag_q});
	assign q0       = slot_prod_s1[30+AW:31];
	assign qd_hi    = {1'b0, qd_s2} + {1'b0, SLOT_DIV};
	assign q_low    = {1'b0, last_q} < qd_s2;
	assign q_up     = {2'b0, last_q} >= qd_hi;
	assign warm_in  = warm_q < CW'(TABLE_SIZE);

	always_comb begin
		if (q_low) begin
			q_fix = {1'b0, q0_s2} - (AW + 1)'(1);
		end else if (q_up) begin
			q_fix = {1'b0, q0_s2} + (AW + 1)'(1);
		end else begin
			q_fix = {1'b0, q0_s2};
		end
		if (q_fix > SLOT_TOP) begin
			q_fix = SLOT_TOP;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q      <= SEED_RESET;
			last_q      <= '0;
			warm_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (seed_wr_en) begin
				seed_q <= seed_wr_data;
			end
			if (cmd.seed_en) begin
				warm_q <= WARM_START;
			end else if (cmd.warm_wr && (warm_q != '0)) begin
				warm_q <= warm_q - CW'(1);
			end
			if (cmd.warm_wr && (warm_q == '0)) begin
				last_q <= gen_q;
			end else if (cmd.draw_done) begin
				last_q <= ram_rdata;
			end
			if (cmd.draw_done) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mag_en) begin
			mag_q <= seed_q[31] ? (32'd0 - seed_q) : seed_q;
		end
		if (cmd.seed_en) begin
			gen_q <= (seed_red == '0) ? 31'd1 : seed_red;
		end else if (cmd.step_red) begin
			gen_q <= lmod_fold(gen_prod_s1);
		end
		if (cmd.step_mul) begin
			gen_prod_s1  <= {15'b0, gen_q} * {31'b0, LEHMER_MUL};
			slot_prod_s1 <= {{AW{1'b0}}, last_q} * (31 + AW)'(TABLE_SIZE);
		end
		if (cmd.step_red) begin
			q0_s2 <= q0;
			qd_s2 <= {{(32 - AW){1'b0}}, q0} * SLOT_DIV;
		end
		if (cmd.slot_fix) begin
			slot_q <= q_fix[AW-1:0];
		end
		if (cmd.draw_done) begin
			deviate_q <= ram_rdata;
		end
	end

	assign ram_we    = (cmd.warm_wr && warm_in) || cmd.draw_done;
	assign ram_waddr = cmd.warm_wr ? warm_q[AW-1:0] : slot_q;

	slug_ram #(
		.WIDTH(31),
		.DEPTH(TABLE_SIZE)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(gen_q),
		.raddr(slot_q),
		.rdata(ram_rdata)
	);

	assign st.filled    = last_q != '0;
	assign st.warm_last = warm_q == '0;
	assign st.out_full  = out_valid_q && out_stall;
	assign out_valid    = out_valid_q;
	assign deviate      = deviate_q;

endmodule

// ===== rtl/core/shuffled_lehmer_uniform_generator.sv =====
// Top level of the shuffled Lehmer uniform generator: controller plus datapath.
// Depends on slug_pkg, slug_ctrl, slug_dp and slug_ram.
//
// Each accepted word with draw set yields one deviate in 1..2^31-2; the uniform value is
// deviate / (2^31-1). A word with draw clear is taken and dropped. After acceptance the
// result word passes through the multiply by 16807, the mod 2^31-1 fold and slot
// estimate, the slot correction, the registered table read and the load of the output
// register. The input is taken again once the output register is loaded, so a new draw
// is not taken before the last one is through. The first draw after reset also loads the
// seed and runs TABLE_SIZE+8 warm-up steps (multiply, fold, table write; the first eight
// steps write nothing to the table). The seed is read only on that first draw. Input is
// taken while a finished word still waits at the output; a second finished draw then
// holds the input until the waiting word is taken.
module shuffled_lehmer_uniform_generator #(
	parameter int TABLE_SIZE = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        seed_wr_en,
	input  logic [31:0] seed_wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        draw,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [30:0] deviate
);
	import slug_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t st;

	slug_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.draw    (draw),
		.in_stall(in_stall),
		.st      (st),
		.cmd     (cmd)
	);

	slug_dp #(
		.TABLE_SIZE(TABLE_SIZE)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.seed_wr_en  (seed_wr_en),
		.seed_wr_data(seed_wr_data),
		.cmd         (cmd),
		.st          (st),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.deviate     (deviate)
	);

`ifndef SYNTH
	a_done_filled: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.draw_done |-> st.filled)
		else $error("draw finished with an empty table");
	a_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (deviate != '0))
		else $error("zero deviate word");
	a_busy_after_draw: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && draw) |=> in_stall)
		else $error("input taken while a draw is in progress");
	a_out_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !cmd.draw_done) |=> !out_valid)
		else $error("output word not dropped after transfer");
`endif

endmodule

// ===== sim/shuffled_lehmer_uniform_generator_test.sv =====
// Self-checking bench for shuffled_lehmer_uniform_generator: random-gap driver and monitor
// around an in-bench shuffled Lehmer predictor, with seed writes between phases.
// Depends on the RTL top level and its package; reads no files.
module shuffled_lehmer_uniform_generator_test;

	localparam int TABLE_SIZE = 32;
	localparam logic [63:0] MULT = 64'd16807;
	localparam logic [63:0] MODULUS = 64'd2147483647;
	localparam logic [31:0] SLOT_SPAN = 32'd1 + 32'd2147483646 / TABLE_SIZE;
	localparam logic [31:0] SEED_AT_RESET = 32'd123456;
	localparam int HOLD_CYCLES = 150;
	localparam int DRAIN_CYCLES = 30;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic seed_wr_en = 1'b0;
	logic [31:0] seed_wr_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic draw = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [30:0] deviate;

	logic draw_words[$];
	logic [30:0] deviates_due[$];
	logic [30:0] want;
	int errors = 0;
	int send_gap_pct = 35;
	int take_gap_pct = 35;
	logic squeeze = 1'b0;
	logic held = 1'b0;
	int hold_left = 0;

	logic [31:0] seed_copy = SEED_AT_RESET;
	logic [30:0] lcg_state = '0;
	logic [30:0] last_deviate = '0;
	logic [30:0] shuffle_slots[TABLE_SIZE];

	shuffled_lehmer_uniform_generator #(
		.TABLE_SIZE(TABLE_SIZE)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.seed_wr_en(seed_wr_en),
		.seed_wr_data(seed_wr_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.draw(draw),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.deviate(deviate)
	);

	function automatic logic [30:0] lehmer_step(input logic [30:0] x);
		logic [63:0] p;
		p = {33'd0, x} * MULT;
		return 31'(p % MODULUS);
	endfunction

	function automatic logic [30:0] seed_origin(input logic [31:0] raw);
		logic [31:0] mag;
		mag = raw[31] ? (32'd0 - raw) : raw;
		mag = mag % 32'd2147483647;
		if (mag == 32'd0)
			mag = 32'd1;
		return mag[30:0];
	endfunction

	function automatic logic [30:0] next_deviate();
		logic [31:0] slot;
		logic [30:0] picked;
		// fill the table on the first draw after reset
		if (last_deviate == 31'd0) begin
			lcg_state = seed_origin(seed_copy);
			for (int j = TABLE_SIZE + 7; j >= 0; j--) begin
				lcg_state = lehmer_step(lcg_state);
				if (j < TABLE_SIZE)
					shuffle_slots[j] = lcg_state;
			end
			last_deviate = shuffle_slots[0];
		end
		lcg_state = lehmer_step(lcg_state);
		slot = {1'b0, last_deviate} / SLOT_SPAN;
		if (slot >= TABLE_SIZE)
			slot = TABLE_SIZE - 1;
		picked = shuffle_slots[slot];
		shuffle_slots[slot] = lcg_state;
		last_deviate = picked;
		return picked;
	endfunction

	task automatic load_seed(input logic [31:0] value);
		@(posedge clk);
		seed_wr_en <= 1'b1;
		seed_wr_data <= value;
		seed_copy = value;
		@(posedge clk);
		seed_wr_en <= 1'b0;
	endtask

	task automatic queue_draws(input int count);
		@(negedge clk);
		for (int i = 0; i < count; i++)
			draw_words.push_back($urandom_range(99) >= 12);
	endtask

	task automatic settle();
		while (draw_words.size() != 0 || in_valid || deviates_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		forever #5 clk = ~clk;
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			draw <= 1'b0;
		end else begin
			if (in_valid && !in_stall && draw)
				deviates_due.push_back(next_deviate());
			if (!in_valid || !in_stall) begin
				if (draw_words.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
					in_valid <= 1'b1;
					draw <= draw_words.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_left <= 0;
			held <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (deviates_due.size() == 0) begin
					$error("deviate: expected none, actual %0d", deviate);
					errors++;
				end else begin
					want = deviates_due.pop_front();
					if (deviate !== want) begin
						$error("deviate: expected %0d, actual %0d", want, deviate);
						errors++;
					end
				end
			end
			if (hold_left != 0) begin
				out_stall <= 1'b1;
				hold_left <= hold_left - 1;
			end else if (squeeze && !held) begin
				held <= 1'b1;
				hold_left <= HOLD_CYCLES;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < take_gap_pct);
			end
		end
	end

	initial begin
		#2000000;
		$display("shuffled_lehmer_uniform_generator regression: fail");
		$finish;
	end

	initial begin
		logic [31:0] first_seed;
		repeat (10) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		first_seed = $urandom;
		if (first_seed == 32'h7FFF_FFFF || first_seed == 32'h8000_0000 ||
				first_seed == 32'h8000_0001)
			first_seed = SEED_AT_RESET;
		case ($urandom_range(5))
			0: first_seed = 32'd0;
			1: first_seed = 32'h8000_0002;
			2: first_seed = 32'h7FFF_FFFE;
			3: first_seed = 32'hFFFF_FFFF;
			4: first_seed = SEED_AT_RESET;
			default: ;
		endcase
		load_seed(32'h7FFF_FFFE);
		load_seed(first_seed);

		// first draw with warm-up, dropped words, back-to-back draws
		@(negedge clk);
		draw_words.push_back(1'b1);
		draw_words.push_back(1'b0);
		draw_words.push_back(1'b1);
		draw_words.push_back(1'b1);
		draw_words.push_back(1'b0);
		draw_words.push_back(1'b0);
		draw_words.push_back(1'b1);
		for (int i = 0; i < 14; i++)
			draw_words.push_back(1'b1);
		settle();

		// late seed writes must not disturb the sequence
		load_seed(32'h8000_0002);
		queue_draws(143);
		settle();

		load_seed(32'd0);
		@(negedge clk);
		send_gap_pct = 0;
		take_gap_pct = 0;
		squeeze = 1'b1;
		queue_draws(143);
		settle();

		load_seed(32'h7FFF_FFFE);
		load_seed(32'hFFFF_FFFF);
		@(negedge clk);
		send_gap_pct = 35;
		take_gap_pct = 35;
		queue_draws(143);
		settle();

		if (errors == 0 && deviates_due.size() == 0)
			$display("shuffled_lehmer_uniform_generator regression: pass");
		else
			$display("shuffled_lehmer_uniform_generator regression: fail");
		$finish;
	end

endmodule

// ===== shuffled_lehmer_uniform_generator.f =====
rtl/core/slug_pkg.sv
rtl/core/slug_ram.sv
rtl/core/slug_ctrl.sv
rtl/core/slug_dp.sv
rtl/core/shuffled_lehmer_uniform_generator.sv
sim/shuffled_lehmer_uniform_generator_test.sv
